FILE: design/numlex_pkg.sv
// numlex_pkg: shared types and constants for the numeric/identifier lexer.
// Token kind codes, character constants and the controller/datapath structs.
// No dependencies.
`default_nettype none

package numlex_pkg;

    localparam int SYM_W = 9;

    typedef logic [2:0] t_kind;

    localparam t_kind K_ID  = 3'd0;
    localparam t_kind K_DEC = 3'd1;
    localparam t_kind K_OCT = 3'd2;
    localparam t_kind K_HEX = 3'd3;
    localparam t_kind K_FLT = 3'd4;
    localparam t_kind K_CHR = 3'd5;
    localparam t_kind K_END = 3'd6;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic is_end;
        logic space;
        logic alpha;
        logic digit;
        logic octal;
        logic hexd;
        logic zero;
        logic expc;
        logic xch;
        logic dot;
        logic sign;
    } t_cls;

    typedef struct packed {
        t_cls cls;
        logic out_free;
        logic hold_valid;
        logic q_last;
    } t_sts;

    typedef struct packed {
        logic  fresh;
        logic  step;
        logic  emit;
        t_kind kind;
        logic  use_dot;
        logic  hold;
        logic  clr_pend;
        logic  give_back;
        logic  finish;
        logic  flush;
    } t_cmd;

endpackage

`default_nettype wire

FILE: design/numlex_dp.sv
// numlex_dp: lexer datapath - character classes, pending store, rescan queue,
// token hold register and output register.
// Depends on numlex_pkg.
`default_nettype none

module numlex_dp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [7:0]            i_in_byte,
    input  wire logic                  i_in_end,
    input  wire logic                  i_m_tready,
    input  wire numlex_pkg::t_cmd      i_cmd,
    output numlex_pkg::t_sts           o_sts,
    output logic                       o_m_tvalid,
    output logic [7:0]                 o_m_tdata,
    output logic [2:0]                 o_m_tuser,
    output logic                       o_m_tlast
);

    logic [numlex_pkg::SYM_W-1:0] r_rq [3];
    logic [numlex_pkg::SYM_W-1:0] n_rq [3];
    logic [1:0]                   r_qhead, n_qhead;
    logic [7:0]                   r_pend [2];
    logic [7:0]                   n_pend [2];
    logic [1:0]                   r_pcnt, n_pcnt;

    logic                         r_hval, n_hval;
    numlex_pkg::t_kind            r_hkind, n_hkind;
    logic [7:0]                   r_hchar, n_hchar;

    logic                         r_oval, n_oval;
    numlex_pkg::t_kind            r_okind, n_okind;
    logic [7:0]                   r_ochar, n_ochar;
    logic                         r_olast, n_olast;

    logic [numlex_pkg::SYM_W-1:0] w_rsym, w_sym;
    logic [7:0]                   w_b;
    logic                         w_live;
    numlex_pkg::t_cls             w_cls;
    logic [7:0]                   w_nchar;
    logic                         w_out_free;

    always_comb begin
        case (r_qhead)
            2'd0:    w_rsym = r_rq[0];
            2'd1:    w_rsym = r_rq[1];
            default: w_rsym = r_rq[2];
        endcase
        w_sym  = i_cmd.fresh ? {i_in_end, i_in_byte} : w_rsym;
        w_b    = w_sym[7:0];
        w_live = !w_sym[8];

        w_cls.is_end = w_sym[8];
        w_cls.space  = w_live && (w_b == numlex_pkg::CH_SPACE ||
                                  (w_b >= 8'd9 && w_b <= 8'd13));
        w_cls.alpha  = w_live && ((w_b >= 8'h61 && w_b <= 8'h7A) ||
                                  (w_b >= 8'h41 && w_b <= 8'h5A));
        w_cls.digit  = w_live && w_b >= numlex_pkg::CH_0 && w_b <= numlex_pkg::CH_9;
        w_cls.octal  = w_live && w_b >= numlex_pkg::CH_0 && w_b <= numlex_pkg::CH_7;
        w_cls.hexd   = w_cls.digit || (w_live && ((w_b >= 8'h61 && w_b <= 8'h66) ||
                                                  (w_b >= 8'h41 && w_b <= 8'h46)));
        w_cls.zero   = w_live && w_b == numlex_pkg::CH_0;
        w_cls.expc   = w_live && (w_b == numlex_pkg::CH_LE || w_b == numlex_pkg::CH_UE);
        w_cls.xch    = w_live && (w_b == numlex_pkg::CH_LX || w_b == numlex_pkg::CH_UX);
        w_cls.dot    = w_live && w_b == numlex_pkg::CH_DOT;
        w_cls.sign   = w_live && (w_b == numlex_pkg::CH_PLUS ||
                                  w_b == numlex_pkg::CH_MINUS);
    end

    assign w_out_free = !r_oval || i_m_tready;

    assign o_sts.cls        = w_cls;
    assign o_sts.out_free   = w_out_free;
    assign o_sts.hold_valid = r_hval;
    assign o_sts.q_last     = (r_qhead == 2'd2);

    always_comb begin
        if (i_cmd.kind == numlex_pkg::K_CHR) begin
            w_nchar = i_cmd.use_dot ? numlex_pkg::CH_DOT : w_b;
        end else begin
            w_nchar = 8'd0;
        end
    end

    // rescan queue and pending store
    always_comb begin
        n_rq    = r_rq;
        n_qhead = r_qhead;
        n_pend  = r_pend;
        n_pcnt  = r_pcnt;
        if (i_cmd.step) begin
            if (i_cmd.give_back) begin
                if (i_cmd.fresh) begin
                    n_rq[2] = w_sym;
                    case (r_pcnt)
                        2'd1: begin
                            n_rq[1] = {1'b0, r_pend[0]};
                            n_qhead = 2'd1;
                        end
                        2'd2: begin
                            n_rq[0] = {1'b0, r_pend[0]};
                            n_rq[1] = {1'b0, r_pend[1]};
                            n_qhead = 2'd0;
                        end
                        default: n_qhead = 2'd2;
                    endcase
                end
                n_pcnt = 2'd0;
            end else begin
                if (!i_cmd.fresh) begin
                    n_qhead = r_qhead + 2'd1;
                end
                if (i_cmd.clr_pend) begin
                    n_pcnt = 2'd0;
                end else if (i_cmd.hold && r_pcnt < 2'd2) begin
                    n_pend[r_pcnt[0]] = w_b;
                    n_pcnt = r_pcnt + 2'd1;
                end
            end
        end
    end

    // token hold and output register
    always_comb begin
        n_hval  = r_hval;
        n_hkind = r_hkind;
        n_hchar = r_hchar;
        n_oval  = r_oval && !i_m_tready;
        n_okind = r_okind;
        n_ochar = r_ochar;
        n_olast = r_olast;
        if (i_cmd.step) begin
            if (i_cmd.emit) begin
                if (r_hval) begin
                    n_oval  = 1'b1;
                    n_okind = r_hkind;
                    n_ochar = r_hchar;
                    n_olast = 1'b0;
                    n_hkind = i_cmd.kind;
                    n_hchar = w_nchar;
                end else if (i_cmd.finish) begin
                    n_oval  = 1'b1;
                    n_okind = i_cmd.kind;
                    n_ochar = w_nchar;
                    n_olast = 1'b1;
                end else begin
                    n_hval  = 1'b1;
                    n_hkind = i_cmd.kind;
                    n_hchar = w_nchar;
                end
            end else if (i_cmd.finish && r_hval) begin
                n_oval  = 1'b1;
                n_okind = r_hkind;
                n_ochar = r_hchar;
                n_olast = 1'b1;
                n_hval  = 1'b0;
            end
        end else if (i_cmd.flush) begin
            n_oval  = 1'b1;
            n_okind = r_hkind;
            n_ochar = r_hchar;
            n_olast = 1'b1;
            n_hval  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qhead <= 2'd3;
            r_pcnt  <= 2'd0;
            r_hval  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_qhead <= n_qhead;
            r_pcnt  <= n_pcnt;
            r_hval  <= n_hval;
            r_oval  <= n_oval;
        end
        r_rq    <= n_rq;
        r_pend  <= n_pend;
        r_hkind <= n_hkind;
        r_hchar <= n_hchar;
        r_okind <= n_okind;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

    assign o_m_tvalid = r_oval;
    assign o_m_tdata  = r_ochar;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

endmodule

`default_nettype wire

FILE: design/numlex_ctrl.sv
// numlex_ctrl: lexer controller - scanner state machine and the sequencer
// that runs fresh characters, rescans and the final token flush.
// Depends on numlex_pkg.
`default_nettype none

module numlex_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire numlex_pkg::t_sts  i_sts,
    output logic                   o_s_tready,
    output numlex_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_IDENT = 4'd1;
    localparam logic [3:0] S_ZERO  = 4'd2;
    localparam logic [3:0] S_OCTN  = 4'd3;
    localparam logic [3:0] S_HEXP  = 4'd4;
    localparam logic [3:0] S_HEXN  = 4'd5;
    localparam logic [3:0] S_DECN  = 4'd6;
    localparam logic [3:0] S_DOT   = 4'd7;
    localparam logic [3:0] S_FRAC  = 4'd8;
    localparam logic [3:0] S_DEC_E = 4'd9;
    localparam logic [3:0] S_DEC_S = 4'd10;
    localparam logic [3:0] S_FLT_E = 4'd11;
    localparam logic [3:0] S_FLT_S = 4'd12;
    localparam logic [3:0] S_EXPN  = 4'd13;

    localparam logic [1:0] M_RUN    = 2'd0;
    localparam logic [1:0] M_REPLAY = 2'd1;
    localparam logic [1:0] M_FLUSH  = 2'd2;

    logic [3:0] r_scan, n_scan, w_scan;
    logic [1:0] r_mode, n_mode;

    logic              w_emit, w_gb, w_hold, w_clr, w_dot;
    numlex_pkg::t_kind w_kind;
    numlex_pkg::t_cls  c;
    logic              w_step, w_fresh, w_finish;

    assign c = i_sts.cls;

    // scanner next state for the current symbol
    always_comb begin
        w_scan = r_scan;
        w_emit = 1'b0;
        w_gb   = 1'b0;
        w_hold = 1'b0;
        w_clr  = 1'b0;
        w_dot  = 1'b0;
        w_kind = numlex_pkg::K_ID;
        case (r_scan)
            S_IDLE: begin
                if (c.is_end) begin
                    w_emit = 1'b1;
                    w_kind = numlex_pkg::K_END;
                end else if (c.space) begin
                    w_scan = S_IDLE;
                end else if (c.alpha) begin
                    w_scan = S_IDENT;
                end else if (c.zero) begin
                    w_scan = S_ZERO;
                end else if (c.digit) begin
                    w_scan = S_DECN;
                end else if (c.dot) begin
                    w_scan = S_DOT;
                end else begin
                    w_emit = 1'b1;
                    w_kind = numlex_pkg::K_CHR;
                end
            end
            S_IDENT: begin
                if (!(c.alpha || c.digit)) begin
                    w_gb = 1'b1;
                    w_kind = numlex_pkg::K_ID;
                end
            end
            S_ZERO: begin
                if (c.octal) begin
                    w_scan = S_OCTN;
                end else if (c.xch) begin
                    w_hold = 1'b1;
                    w_scan = S_HEXP;
                end else if (c.dot) begin
                    w_scan = S_FRAC;
                end else if (c.expc) begin
                    w_hold = 1'b1;
                    w_scan = S_DEC_E;
                end else begin
                    w_gb = 1'b1;
                    w_kind = numlex_pkg::K_DEC;
                end
            end
            S_OCTN: begin
                if (!c.octal) begin
                    w_gb = 1'b1;
                    w_kind = numlex_pkg::K_OCT;
                end
            end
            S_HEXP: begin
                if (c.hexd) begin
                    w_clr  = 1'b1;
                    w_scan = S_HEXN;
                end else begin
                    w_gb = 1'b1;
                    w_kind = numlex_pkg::K_DEC;
                end
            end
            S_HEXN: begin
                if (!c.hexd) begin
                    w_gb = 1'b1;
                    w_kind = numlex_pkg::K_HEX;
                end
            end
            S_DECN: begin
                if (c.digit) begin
                    w_scan = S_DECN;
                end else if (c.expc) begin
                    w_hold = 1'b1;
                    w_scan = S_DEC_E;
                end else if (c.dot) begin
                    w_scan = S_FRAC;
                end else begin
                    w_gb = 1'b1;
                    w_kind = numlex_pkg::K_DEC;
                end
            end
            S_DOT: begin
                if (c.digit) begin
                    w_scan = S_FRAC;
                end else begin
                    w_gb   = 1'b1;
                    w_kind = numlex_pkg::K_CHR;
                    w_dot  = 1'b1;
                end
            end
            S_FRAC: begin
                if (c.digit) begin
                    w_scan = S_FRAC;
                end else if (c.expc) begin
                    w_hold = 1'b1;
                    w_scan = S_FLT_E;
                end else begin
                    w_gb = 1'b1;
                    w_kind = numlex_pkg::K_FLT;
                end
            end
            S_DEC_E, S_FLT_E: begin
                if (c.sign) begin
                    w_hold = 1'b1;
                    w_scan = r_scan + 4'd1;
                end else if (c.digit) begin
                    w_clr  = 1'b1;
                    w_scan = S_EXPN;
                end else begin
                    w_gb = 1'b1;
                    w_kind = (r_scan == S_DEC_E) ? numlex_pkg::K_DEC : numlex_pkg::K_FLT;
                end
            end
            S_DEC_S, S_FLT_S: begin
                if (c.digit) begin
                    w_clr  = 1'b1;
                    w_scan = S_EXPN;
                end else begin
                    w_gb = 1'b1;
                    w_kind = (r_scan == S_DEC_S) ? numlex_pkg::K_DEC : numlex_pkg::K_FLT;
                end
            end
            S_EXPN: begin
                if (!c.digit) begin
                    w_gb = 1'b1;
                    w_kind = numlex_pkg::K_FLT;
                end
            end
            default: begin
                w_gb = 1'b1;
                w_clr = 1'b1;
            end
        endcase
        if (w_gb) begin
            w_scan = S_IDLE;
            if (r_scan <= S_EXPN) begin
                w_emit = 1'b1;
            end
        end
    end

    assign w_fresh    = (r_mode == M_RUN);
    assign o_s_tready = w_fresh && i_sts.out_free;
    assign w_step     = i_sts.out_free &&
                        ((w_fresh && i_s_tvalid) || r_mode == M_REPLAY);
    assign w_finish   = w_step && !w_gb && (w_fresh || i_sts.q_last);

    always_comb begin
        o_cmd.fresh     = w_fresh;
        o_cmd.step      = w_step;
        o_cmd.emit      = w_emit;
        o_cmd.kind      = w_kind;
        o_cmd.use_dot   = w_dot;
        o_cmd.hold      = w_hold;
        o_cmd.clr_pend  = w_clr;
        o_cmd.give_back = w_gb;
        o_cmd.finish    = w_finish;
        o_cmd.flush     = (r_mode == M_FLUSH) && i_sts.out_free;
    end

    always_comb begin
        n_scan = r_scan;
        n_mode = r_mode;
        case (r_mode)
            M_RUN, M_REPLAY: begin
                if (w_step) begin
                    n_scan = w_scan;
                    if (w_gb) begin
                        n_mode = M_REPLAY;
                    end else if (w_finish) begin
                        n_mode = (w_emit && i_sts.hold_valid) ? M_FLUSH : M_RUN;
                    end
                end
            end
            M_FLUSH: begin
                if (i_sts.out_free) begin
                    n_mode = M_RUN;
                end
            end
            default: n_mode = M_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= S_IDLE;
            r_mode <= M_RUN;
        end else begin
            r_scan <= n_scan;
            r_mode <= n_mode;
        end
    end

endmodule

`default_nettype wire

FILE: design/numeric_identifier_lexer.sv
// numeric_identifier_lexer: one character per cycle in, one token per cycle out,
// while no rescan or flush runs and the output has room. A failed token rescans its
// held characters, and an item whose last step emits while a token is held adds a
// flush of that token; no input is taken meanwhile. Output tokens are registered.
// Reset: synchronous active low; scanner idle, no held characters, outputs empty.
// Depends on numlex_pkg, numlex_ctrl and numlex_dp.
`default_nettype none

module numeric_identifier_lexer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tlast,   // end_of_input
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] char_value
    output logic [2:0]      o_m_axis_tuser,   // [2:0] token_kind
    output logic            o_m_axis_tlast    // last_of_run
);

    numlex_pkg::t_cmd w_cmd;
    numlex_pkg::t_sts w_sts;

    numlex_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_sts      (w_sts),
        .o_s_tready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    numlex_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_byte  (i_s_axis_tdata),
        .i_in_end   (i_s_axis_tlast),
        .i_m_tready (i_m_axis_tready),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser),
        .o_m_tlast  (o_m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    a_step_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> w_sts.out_free)
        else $error("scan step without output room");

    a_gb_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.give_back |-> !w_cmd.finish)
        else $error("rescan and item finish together");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == numlex_pkg::K_END) |-> o_m_axis_tlast)
        else $error("end token not last of run");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != numlex_pkg::K_CHR) |->
        o_m_axis_tdata == 8'd0)
        else $error("nonzero char value on non-character token");
`endif

endmodule

`default_nettype wire

FILE: bench/numlex_checker.sv
// numlex_checker: watches both stream channels of the lexer, predicts the token
// stream from the accepted characters and compares every output transaction.
// Depends on numlex_pkg.

module numlex_checker
    import numlex_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] in_byte
    input  logic       i_s_tlast,    // end_of_input
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,    // [7:0] char_value
    input  logic [2:0] i_m_tuser,    // [2:0] token_kind
    input  logic       i_m_tlast,    // last_of_run
    output int         o_fail_count,
    output int         o_due_count,
    output int         o_char_count,
    output int         o_token_count,
    output logic [6:0] o_kinds_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SYM_W-1:0] SYM_EOF = 9'h100;
    localparam int MAX_TOKENS = 5;
    localparam int MAX_HELD = 3;

    typedef enum logic [3:0] {
        SC_IDLE, SC_IDENT, SC_ZERO, SC_OCTN, SC_HEXP, SC_HEXN, SC_DECN,
        SC_DOT, SC_FRAC, SC_DEC_E, SC_DEC_S, SC_FLT_E, SC_FLT_S, SC_EXPN
    } scan_state_e;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
        logic       last;
    } token_t;

    scan_state_e      lex_state;
    logic [7:0]       held_chars [MAX_HELD];
    int               held_n;
    logic [SYM_W-1:0] rescan_q[$];
    token_t           run_q[$];
    token_t           tokens_due[$];

    function automatic logic is_ch(input logic [SYM_W-1:0] s, input logic [7:0] c);
        return s == {1'b0, c};
    endfunction

    function automatic logic is_digit(input logic [SYM_W-1:0] s);
        return !s[8] && s[7:0] >= CH_0 && s[7:0] <= CH_9;
    endfunction

    function automatic logic is_octal(input logic [SYM_W-1:0] s);
        return !s[8] && s[7:0] >= CH_0 && s[7:0] <= CH_7;
    endfunction

    function automatic logic is_alpha(input logic [SYM_W-1:0] s);
        return !s[8] && ((s[7:0] >= 8'h61 && s[7:0] <= 8'h7A) ||
                         (s[7:0] >= 8'h41 && s[7:0] <= 8'h5A));
    endfunction

    function automatic logic is_hexd(input logic [SYM_W-1:0] s);
        return is_digit(s) || (!s[8] && ((s[7:0] >= 8'h61 && s[7:0] <= 8'h66) ||
                                         (s[7:0] >= 8'h41 && s[7:0] <= 8'h46)));
    endfunction

    function automatic logic is_space(input logic [SYM_W-1:0] s);
        return !s[8] && (s[7:0] == CH_SPACE || (s[7:0] >= 8'd9 && s[7:0] <= 8'd13));
    endfunction

    function automatic logic is_expch(input logic [SYM_W-1:0] s);
        return is_ch(s, CH_LE) || is_ch(s, CH_UE);
    endfunction

    function automatic logic is_sign(input logic [SYM_W-1:0] s);
        return is_ch(s, CH_PLUS) || is_ch(s, CH_MINUS);
    endfunction

    task automatic add_token(input t_kind kind, input logic [7:0] c);
        token_t t;
        t.kind = kind;
        t.code = (kind == K_CHR) ? c : 8'h00;
        t.last = 1'b0;
        if (run_q.size() < MAX_TOKENS)
            run_q.push_back(t);
    endtask

    task automatic hold_char(input logic [SYM_W-1:0] s);
        if (held_n < MAX_HELD) begin
            held_chars[held_n] = s[7:0];
            held_n++;
        end
    endtask

    // token decided late: emit it, then rescan held chars followed by s
    task automatic settle(input t_kind kind, input logic [7:0] c,
                          input logic [SYM_W-1:0] s);
        add_token(kind, c);
        rescan_q.push_front(s);
        for (int i = held_n - 1; i >= 0; i--)
            rescan_q.push_front({1'b0, held_chars[i]});
        held_n = 0;
        lex_state = SC_IDLE;
    endtask

    task automatic scan_symbol(input logic [SYM_W-1:0] s);
        case (lex_state)
            SC_IDLE: begin
                if (s == SYM_EOF) add_token(K_END, 8'h00);
                else if (is_space(s)) lex_state = SC_IDLE;
                else if (is_alpha(s)) lex_state = SC_IDENT;
                else if (is_ch(s, CH_0)) lex_state = SC_ZERO;
                else if (is_digit(s)) lex_state = SC_DECN;
                else if (is_ch(s, CH_DOT)) lex_state = SC_DOT;
                else add_token(K_CHR, s[7:0]);
            end
            SC_IDENT: begin
                if (!(is_alpha(s) || is_digit(s))) settle(K_ID, 8'h00, s);
            end
            SC_ZERO: begin
                if (is_octal(s)) lex_state = SC_OCTN;
                else if (is_ch(s, CH_LX) || is_ch(s, CH_UX)) begin
                    hold_char(s);
                    lex_state = SC_HEXP;
                end else if (is_ch(s, CH_DOT)) lex_state = SC_FRAC;
                else if (is_expch(s)) begin
                    hold_char(s);
                    lex_state = SC_DEC_E;
                end else settle(K_DEC, 8'h00, s);
            end
            SC_OCTN: begin
                if (!is_octal(s)) settle(K_OCT, 8'h00, s);
            end
            SC_HEXP: begin
                if (is_hexd(s)) begin
                    held_n = 0;
                    lex_state = SC_HEXN;
                end else settle(K_DEC, 8'h00, s);
            end
            SC_HEXN: begin
                if (!is_hexd(s)) settle(K_HEX, 8'h00, s);
            end
            SC_DECN: begin
                if (is_digit(s)) lex_state = SC_DECN;
                else if (is_expch(s)) begin
                    hold_char(s);
                    lex_state = SC_DEC_E;
                end else if (is_ch(s, CH_DOT)) lex_state = SC_FRAC;
                else settle(K_DEC, 8'h00, s);
            end
            SC_DOT: begin
                if (is_digit(s)) lex_state = SC_FRAC;
                else settle(K_CHR, CH_DOT, s);
            end
            SC_FRAC: begin
                if (is_digit(s)) lex_state = SC_FRAC;
                else if (is_expch(s)) begin
                    hold_char(s);
                    lex_state = SC_FLT_E;
                end else settle(K_FLT, 8'h00, s);
            end
            SC_DEC_E, SC_FLT_E: begin
                if (is_sign(s)) begin
                    hold_char(s);
                    lex_state = (lex_state == SC_DEC_E) ? SC_DEC_S : SC_FLT_S;
                end else if (is_digit(s)) begin
                    held_n = 0;
                    lex_state = SC_EXPN;
                end else settle((lex_state == SC_DEC_E) ? K_DEC : K_FLT, 8'h00, s);
            end
            SC_DEC_S, SC_FLT_S: begin
                if (is_digit(s)) begin
                    held_n = 0;
                    lex_state = SC_EXPN;
                end else settle((lex_state == SC_DEC_S) ? K_DEC : K_FLT, 8'h00, s);
            end
            SC_EXPN: begin
                if (!is_digit(s)) settle(K_FLT, 8'h00, s);
            end
            default: begin
                held_n = 0;
                lex_state = SC_IDLE;
                rescan_q.push_front(s);
            end
        endcase
    endtask

    task automatic lex_char(input logic [7:0] b, input logic eoi);
        int guard;
        guard = 0;
        run_q.delete();
        rescan_q.delete();
        rescan_q.push_back(eoi ? SYM_EOF : {1'b0, b});
        while (rescan_q.size() > 0 && guard < 32) begin
            scan_symbol(rescan_q.pop_front());
            guard++;
        end
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[i])
            tokens_due.push_back(run_q[i]);
    endtask

    always @(posedge i_clk) begin
        token_t want;
        if (!i_rst_n) begin
            lex_state = SC_IDLE;
            held_n = 0;
            tokens_due.delete();
            o_fail_count = 0;
            o_due_count = 0;
            o_char_count = 0;
            o_token_count = 0;
            o_kinds_seen = '0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                lex_char(i_s_tdata, i_s_tlast);
                o_char_count++;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (tokens_due.size() == 0) begin
                    $error("unexpected token transaction: kind %0d char %0d last %0d",
                           i_m_tuser, i_m_tdata, i_m_tlast);
                    o_fail_count++;
                end else begin
                    want = tokens_due.pop_front();
                    o_kinds_seen[want.kind] = 1'b1;
                    o_token_count++;
                    if (i_m_tuser !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, i_m_tuser);
                        o_fail_count++;
                    end
                    if (i_m_tdata !== want.code) begin
                        $error("char_value: expected %0d, got %0d", want.code, i_m_tdata);
                        o_fail_count++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d", want.last, i_m_tlast);
                        o_fail_count++;
                    end
                end
            end
            o_due_count = tokens_due.size();
        end
    end

endmodule

FILE: bench/numeric_identifier_lexer_test.sv
// numeric_identifier_lexer_test: drives character streams into the lexer with
// random gaps and output stalls, and reports the verdict from numlex_checker.
// Depends on numlex_pkg, numeric_identifier_lexer and numlex_checker.

module numeric_identifier_lexer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import numlex_pkg::*;

    localparam int CHAR_TARGET = 340;
    localparam int TAIL_CYCLES = 24;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;
    logic       tx_free = 1'b0;
    logic       rx_free = 1'b0;
    int         fail_count;
    int         due_count;
    int         char_count;
    int         token_count;
    logic [6:0] kinds_seen;
    logic [8:0] lexeme[$];    // bit 8 = end_of_input

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    numeric_identifier_lexer i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    numlex_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_fail_count  (fail_count),
        .o_due_count   (due_count),
        .o_char_count  (char_count),
        .o_token_count (token_count),
        .o_kinds_seen  (kinds_seen)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rnd_digit(input int lo);
        return 8'(CH_0 + $urandom_range(lo, 9));
    endfunction

    function automatic logic [7:0] rnd_alpha();
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rnd_hex();
        string hex_set;
        hex_set = "0123456789abcdefABCDEF";
        return hex_set[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] rnd_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'(9 + r);
    endfunction

    task automatic push_char(input logic [7:0] c);
        lexeme.push_back({1'b0, c});
    endtask

    task automatic push_number();
        push_char(rnd_digit(1));
        repeat ($urandom_range(0, 3)) push_char(rnd_digit(0));
    endtask

    // complete = 0 leaves the exponent without digits
    task automatic push_exponent(input logic complete);
        push_char($urandom_range(0, 1) ? CH_LE : CH_UE);
        if ($urandom_range(0, 1)) push_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        if (complete) repeat ($urandom_range(1, 2)) push_char(rnd_digit(0));
    endtask

    task automatic random_lexeme();
        case ($urandom_range(0, 15))
            0, 1: begin
                push_char(rnd_alpha());
                repeat ($urandom_range(0, 4))
                    push_char($urandom_range(0, 2) ? rnd_alpha() : rnd_digit(0));
            end
            2: push_number();
            3: push_char(CH_0);
            4: begin
                push_char(CH_0);
                repeat ($urandom_range(1, 3)) push_char(8'(CH_0 + $urandom_range(0, 7)));
            end
            5: begin
                push_char(CH_0);
                push_char($urandom_range(0, 1) ? CH_LX : CH_UX);
                repeat ($urandom_range(1, 3)) push_char(rnd_hex());
            end
            6: begin
                push_number();
                push_char(CH_DOT);
                repeat ($urandom_range(0, 2)) push_char(rnd_digit(0));
                if ($urandom_range(0, 1)) push_exponent(1'b1);
            end
            7: begin
                push_char(CH_DOT);
                repeat ($urandom_range(1, 2)) push_char(rnd_digit(0));
                if ($urandom_range(0, 1)) push_exponent(1'b1);
            end
            8: begin
                push_number();
                push_exponent(1'b1);
            end
            9: begin
                push_char(CH_0);
                push_char($urandom_range(0, 1) ? CH_LX : CH_UX);
            end
            10: begin
                push_number();
                if ($urandom_range(0, 1)) push_char(CH_DOT);
                push_exponent(1'b0);
            end
            11: push_char(CH_DOT);
            12: push_char(8'($urandom_range(33, 126)));
            13: push_char(8'($urandom_range(128, 255)));
            14: push_char(8'($urandom));
            default: lexeme.push_back({1'b1, 8'($urandom)});
        endcase
    endtask

    // one input transaction; called and returns at a falling edge
    task automatic send(input logic [7:0] b, input logic eoi);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoi;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        gap = tx_free ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!rx_free && $urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    initial begin : stimulus
        string      directed;
        logic [8:0] ch;
        int         random_chars;
        logic       drained;
        directed = "0X1f\t0xg 08 07.5e+.3E-9.";
        random_chars = 0;
        drained = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < directed.len(); i++)
            send(directed[i], 1'b0);
        send(8'hFF, 1'b0);
        send(8'h00, 1'b0);
        send(8'($urandom), 1'b1);

        while (random_chars < CHAR_TARGET) begin
            if (!drained && random_chars >= 120) begin
                drained = 1'b1;
                s_tvalid <= 1'b0;
                do @(negedge clk); while (due_count != 0);
            end
            tx_free = (random_chars >= 200 && random_chars < 260);
            rx_free <= tx_free;
            random_lexeme();
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 2)) push_char(rnd_space());
            random_chars += lexeme.size();
            while (lexeme.size() > 0) begin
                ch = lexeme.pop_front();
                send(ch[7:0], ch[8]);
            end
        end
        send(8'($urandom), 1'b1);
        s_tvalid <= 1'b0;
        rx_free <= 1'b0;

        while (due_count != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Summary: %0d characters lexed, %0d tokens checked, %0d mismatches",
                 char_count, token_count, fail_count);
        $display("Token kinds seen (end..identifier): %b", kinds_seen);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #1ms;
        $display("Timeout with %0d tokens outstanding", due_count);
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
design/numlex_pkg.sv
design/numlex_dp.sv
design/numlex_ctrl.sv
design/numeric_identifier_lexer.sv
bench/numlex_checker.sv
bench/numeric_identifier_lexer_test.sv
